@@ sv/fsvsi_pkg.sv @@
`timescale 1ns / 1ps

package fsvsi_pkg;

  localparam int unsigned PLANE_W   = 32;
  localparam int unsigned IDX_EXT_W = 40;

  typedef enum logic [1:0] {
    CMD_BASE  = 2'd0,
    CMD_SLICE = 2'd1,
    CMD_INDEX = 2'd2
  } fsvsi_cmd_e;

  typedef struct packed {
    logic [PLANE_W-1:0] up;
    logic [PLANE_W-1:0] vp;
  } fsvsi_planes_t;

  typedef struct packed {
    logic [5:0]         len;
    logic [4:0]         off;
    logic [PLANE_W-1:0] du;
    logic [PLANE_W-1:0] dv;
    logic [1:0]         cmd;
  } fsvsi_item_t;

  typedef struct packed {
    logic          emit;
    fsvsi_planes_t planes;
  } fsvsi_res_t;

  function automatic fsvsi_planes_t write_field(fsvsi_planes_t old, logic [PLANE_W-1:0] dv,
                                                logic [PLANE_W-1:0] du, logic [4:0] off,
                                                logic [5:0] len);
    logic [PLANE_W-1:0] len_mask;
    logic [PLANE_W-1:0] mask;
    fsvsi_planes_t      res;
    len_mask = (len >= 6'd32) ? '1 : ((PLANE_W'(1) << len) - PLANE_W'(1));
    mask     = len_mask << off;
    res.vp   = (old.vp & ~mask) | ((dv << off) & mask);
    res.up   = (old.up & ~mask) | ((du << off) & mask);
    return res;
  endfunction

endpackage

@@ sv/fsvsi_core.sv @@
`timescale 1ns / 1ps

module fsvsi_core #(
  parameter int unsigned VECTOR_WIDTH = 32,
  parameter int unsigned INSERT_WIDTH = 8,
  parameter int unsigned INDEX_WIDTH  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  fsvsi_pkg::fsvsi_item_t item_i,
  input  logic                 signed_base_i,
  output fsvsi_pkg::fsvsi_res_t  res_o
);
  import fsvsi_pkg::*;

  localparam int unsigned PW = $clog2(VECTOR_WIDTH + INSERT_WIDTH) + 1;
  localparam int unsigned SW = (INSERT_WIDTH > 1) ? $clog2(INSERT_WIDTH) : 1;

  logic [VECTOR_WIDTH-1:0] base_vp_q, base_up_q, base_vp_d, base_up_d;
  logic [INSERT_WIDTH-1:0] slice_vp_q, slice_up_q, slice_vp_d, slice_up_d;
  logic [INDEX_WIDTH-1:0]  idx_vp_q, idx_up_q, idx_vp_d, idx_up_d;
  logic [VECTOR_WIDTH-1:0] last_vp_q, last_up_q, last_vp_d, last_up_d;
  logic                    idx_hit_q, idx_hit_d;
  logic signed [PW-1:0]    idx_pos_q, idx_pos_d;

  fsvsi_planes_t           wr_planes;
  fsvsi_planes_t           old_planes;
  logic                    is_base, is_slice, is_index, cmd_ok;
  logic signed [IDX_EXT_W-1:0] idx_ext;
  logic [VECTOR_WIDTH-1:0] new_vp, new_up;

  always_comb begin
    is_base  = 1'b0;
    is_slice = 1'b0;
    is_index = 1'b0;
    case (item_i.cmd)
      CMD_BASE:  is_base  = 1'b1;
      CMD_SLICE: is_slice = 1'b1;
      CMD_INDEX: is_index = 1'b1;
      default:   ;
    endcase
    cmd_ok = is_base | is_slice | is_index;
  end

  always_comb begin
    old_planes = '0;
    if (is_base) begin
      old_planes.vp = PLANE_W'(base_vp_q);
      old_planes.up = PLANE_W'(base_up_q);
    end else if (is_slice) begin
      old_planes.vp = PLANE_W'(slice_vp_q);
      old_planes.up = PLANE_W'(slice_up_q);
    end else begin
      old_planes.vp = PLANE_W'(idx_vp_q);
      old_planes.up = PLANE_W'(idx_up_q);
    end
  end

  assign wr_planes = write_field(old_planes, item_i.dv, item_i.du, item_i.off, item_i.len);

  assign base_vp_d  = (fire_i && is_base)  ? wr_planes.vp[VECTOR_WIDTH-1:0] : base_vp_q;
  assign base_up_d  = (fire_i && is_base)  ? wr_planes.up[VECTOR_WIDTH-1:0] : base_up_q;
  assign slice_vp_d = (fire_i && is_slice) ? wr_planes.vp[INSERT_WIDTH-1:0] : slice_vp_q;
  assign slice_up_d = (fire_i && is_slice) ? wr_planes.up[INSERT_WIDTH-1:0] : slice_up_q;
  assign idx_vp_d   = (fire_i && is_index) ? wr_planes.vp[INDEX_WIDTH-1:0]  : idx_vp_q;
  assign idx_up_d   = (fire_i && is_index) ? wr_planes.up[INDEX_WIDTH-1:0]  : idx_up_q;

  always_comb begin
    if (signed_base_i) begin
      idx_ext = IDX_EXT_W'($signed(idx_vp_d));
    end else begin
      idx_ext = $signed(IDX_EXT_W'(idx_vp_d));
    end
    if (fire_i && is_index) begin
      idx_hit_d = (idx_up_d == '0)
                  && (idx_ext > -$signed(IDX_EXT_W'(INSERT_WIDTH)))
                  && (idx_ext < $signed(IDX_EXT_W'(VECTOR_WIDTH)));
      idx_pos_d = idx_ext[PW-1:0];
    end else begin
      idx_hit_d = idx_hit_q;
      idx_pos_d = idx_pos_q;
    end
  end

  for (genvar j = 0; j < VECTOR_WIDTH; j++) begin : g_overlay
    logic signed [PW:0] diff;
    logic               take;
    assign diff = $signed((PW+1)'(j)) - $signed({idx_pos_d[PW-1], idx_pos_d});
    assign take = idx_hit_d && (diff >= 0) && (diff < $signed((PW+1)'(INSERT_WIDTH)));
    assign new_vp[j] = take ? slice_vp_d[diff[SW-1:0]] : base_vp_d[j];
    assign new_up[j] = take ? slice_up_d[diff[SW-1:0]] : base_up_d[j];
  end

  assign last_vp_d = (fire_i && cmd_ok) ? new_vp : last_vp_q;
  assign last_up_d = (fire_i && cmd_ok) ? new_up : last_up_q;

  always_comb begin
    res_o.emit      = fire_i && cmd_ok && ((new_vp != last_vp_q) || (new_up != last_up_q));
    res_o.planes.vp = PLANE_W'(new_vp);
    res_o.planes.up = PLANE_W'(new_up);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_vp_q  <= '0;
      base_up_q  <= '1;
      slice_vp_q <= '0;
      slice_up_q <= '1;
      idx_vp_q   <= '0;
      idx_up_q   <= '1;
      last_vp_q  <= '0;
      last_up_q  <= '1;
      idx_hit_q  <= 1'b0;
      idx_pos_q  <= '0;
    end else begin
      base_vp_q  <= base_vp_d;
      base_up_q  <= base_up_d;
      slice_vp_q <= slice_vp_d;
      slice_up_q <= slice_up_d;
      idx_vp_q   <= idx_vp_d;
      idx_up_q   <= idx_up_d;
      last_vp_q  <= last_vp_d;
      last_up_q  <= last_up_d;
      idx_hit_q  <= idx_hit_d;
      idx_pos_q  <= idx_pos_d;
    end
  end

endmodule

@@ sv/four_state_variable_slice_insert.sv @@
`timescale 1ns / 1ps
// Four-state variable slice insert.
// Keeps a base vector, a slice and an index, each as a value plane and an
// unknown plane (00=0, 10=1, 11=X, 01=Z). Each input transaction writes a
// field into one of them, selected by tuser; the block then overlays the
// slice on the base vector at the index, clipped at both edges, and emits
// the composed vector only when it differs from the previous one.
// Input: s_axis_* stream; tuser carries cmd, tdata the planes, offset and
// length. Output: m_axis_* stream with both result planes.
// Config: cfg_* write channel, always ready; bit 0 selects signed index
// decoding and applies from the next index write on.
// Throughput: one transaction per cycle while the output is not stalled;
// the state update, overlay and compare sit in one stage between the input
// register and the output register.
// Reset: all vectors read Z, the index is invalid, both stages are empty.
// When the receiver stalls, the output register holds and the input
// register fills, then s_axis_tready drops until the output drains.
module four_state_variable_slice_insert #(
  parameter int unsigned VECTOR_WIDTH = 32,
  parameter int unsigned INSERT_WIDTH = 8,
  parameter int unsigned INDEX_WIDTH  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_value_plane[31:0], data_unknown_plane[63:32], part_offset[68:64],
  // part_length[74:69], zero[79:75]
  input  logic [79:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_value_plane[31:0], result_unknown_plane[63:32]
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import fsvsi_pkg::*;

  logic          in_valid_q;
  fsvsi_item_t   in_item_q;
  logic          out_valid_q;
  fsvsi_planes_t out_planes_q;
  logic          signed_base_q;
  logic          advance;
  fsvsi_res_t    res;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  fsvsi_core #(
    .VECTOR_WIDTH(VECTOR_WIDTH),
    .INSERT_WIDTH(INSERT_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .item_i       (in_item_q),
    .signed_base_i(signed_base_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      signed_base_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && res.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        signed_base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.cmd <= s_axis_tuser;
      in_item_q.dv  <= s_axis_tdata[31:0];
      in_item_q.du  <= s_axis_tdata[63:32];
      in_item_q.off <= s_axis_tdata[68:64];
      in_item_q.len <= s_axis_tdata[74:69];
    end
    if (advance && res.emit) begin
      out_planes_q <= res.planes;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_planes_q.up, out_planes_q.vp};

endmodule

@@ sv/fsvsi_checker.sv @@
`timescale 1ns / 1ps

module fsvsi_checker #(
  parameter int unsigned VECTOR_WIDTH = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  localparam logic [32:0] VFULL = (33'd1 << VECTOR_WIDTH) - 33'd1;

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  a_results_differ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) ##1 (m_axis_tvalid && m_axis_tready)
    |-> m_axis_tdata != $past(m_axis_tdata))
    else $error("two consecutive results are equal");

  a_upper_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[31:0] & ~VFULL[31:0]) == 32'd0)
                   && ((m_axis_tdata[63:32] & ~VFULL[31:0]) == 32'd0))
    else $error("result bits above the vector width are set");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without an input transaction two cycles before");

endmodule

bind four_state_variable_slice_insert fsvsi_checker #(
  .VECTOR_WIDTH(VECTOR_WIDTH)
) u_fsvsi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
